// File: hdl/spms_pkg.sv
// ----------------------------------------------------------------------------
// spms_pkg
// Types and constants shared by the shared-pool multi-stack unit.
// ----------------------------------------------------------------------------
package spms_pkg;

	localparam int POOL_DEPTH = 131072;
	localparam int ADDR_W     = $clog2(POOL_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int ID_W       = 10;
	localparam int VAL_W      = 30;
	localparam int STATUS_W   = 2;

	localparam logic [ID_W-1:0] ID_CLEARED = '0;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic             mode;
		logic [ID_W-1:0]  stack_id;
		logic [VAL_W-1:0] push_value;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    pop_value;
	} out_t;

	typedef struct packed {
		logic                load_item;
		logic                do_push;
		logic                scan_start;
		logic                scan_run;
		logic                res_wr;
		logic [STATUS_W-1:0] res_code;
		logic                load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic id_zero;
		logic pool_empty;
		logic hit;
		logic exhausted;
	} dp_sts_t;

endpackage

// File: hdl/spms_ctrl.sv
// ----------------------------------------------------------------------------
// spms_ctrl
// Sequencer: takes one item, runs push or backward pop scan, hands result out.
// ----------------------------------------------------------------------------
module spms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  spms_pkg::dp_sts_t sts,
	output spms_pkg::dp_cmd_t cmd
);
	import spms_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FETCH,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
			end
			S_DECIDE: begin
				if (!sts.is_pop) begin
					cmd.res_wr = 1'b1;
					if (sts.full) begin
						cmd.res_code = ST_FULL;
					end else begin
						cmd.do_push  = 1'b1;
						cmd.res_code = ST_PUSHED;
					end
				end else if (sts.id_zero || sts.pool_empty) begin
					cmd.res_wr   = 1'b1;
					cmd.res_code = ST_EMPTY;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (!sts.hit && sts.exhausted) begin
					cmd.res_wr   = 1'b1;
					cmd.res_code = ST_EMPTY;
				end
			end
			S_FETCH: begin
				cmd.res_wr   = 1'b1;
				cmd.res_code = ST_POPPED;
			end
			S_EMIT: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (cmd.scan_start) state_q <= S_SCAN;
					else state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (sts.hit) state_q <= S_FETCH;
					else if (sts.exhausted) state_q <= S_EMIT;
				end
				S_FETCH: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.load_out) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/spms_dp.sv
// ----------------------------------------------------------------------------
// spms_dp
// Pool memories, fill point, backward scan pipeline and result registers.
// ----------------------------------------------------------------------------
module spms_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  spms_pkg::in_t     in_data,
	input  spms_pkg::dp_cmd_t cmd,
	output spms_pkg::dp_sts_t sts,
	output spms_pkg::out_t    out_data
);
	import spms_pkg::*;

	logic [ID_W-1:0]  id_mem  [POOL_DEPTH];
	logic [VAL_W-1:0] val_mem [POOL_DEPTH];

	in_t                 item_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic                rd_vld_s1;
	logic [ID_W-1:0]     id_rd_q;
	logic [VAL_W-1:0]    val_rd_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [VAL_W-1:0]    res_value_q;
	out_t                out_q;
	logic                hit;
	logic                clear_wr;
	logic                id_we;
	logic [ADDR_W-1:0]   id_wa;
	logic [ID_W-1:0]     id_wd;
	logic [CNT_W-1:0]    ptr_dec;

	assign ptr_dec  = ptr_q - CNT_W'(1);
	assign rd_addr  = ptr_dec[ADDR_W-1:0];
	assign hit      = rd_vld_s1 && (id_rd_q == item_q.stack_id);
	assign clear_wr = cmd.scan_run && hit;

	assign sts.is_pop     = (item_q.mode == MODE_POP);
	assign sts.full       = (fill_q == CNT_W'(POOL_DEPTH));
	assign sts.id_zero    = (item_q.stack_id == ID_CLEARED);
	assign sts.pool_empty = (fill_q == '0);
	assign sts.hit        = hit;
	assign sts.exhausted  = (ptr_q == '0) && !rd_vld_s1;

	assign out_data = out_q;

	assign id_we = cmd.do_push || clear_wr;
	assign id_wa = cmd.do_push ? fill_q[ADDR_W-1:0] : rd_addr_s1;
	assign id_wd = cmd.do_push ? item_q.stack_id : ID_CLEARED;

	always_ff @(posedge clk) begin
		if (id_we) id_mem[id_wa] <= id_wd;
		id_rd_q <= id_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.do_push) val_mem[fill_q[ADDR_W-1:0]] <= item_q.push_value;
		val_rd_q <= val_mem[rd_addr_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.do_push) fill_q <= fill_q + CNT_W'(1);
			if (cmd.scan_start) begin
				ptr_q     <= fill_q;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_run && !hit) begin
				rd_vld_s1 <= (ptr_q != '0);
				if (ptr_q != '0) ptr_q <= ptr_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_data;
		if (cmd.scan_run && !hit) rd_addr_s1 <= rd_addr;
		if (cmd.res_wr) begin
			res_status_q <= cmd.res_code;
			res_value_q  <= (cmd.res_code == ST_POPPED) ? val_rd_q : '0;
		end
		if (cmd.load_out) begin
			out_q.status    <= res_status_q;
			out_q.pop_value <= res_value_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(POOL_DEPTH))
		else $error("fill point beyond pool depth");

	a_push_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("push did not advance fill point");

	a_clear_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		clear_wr |-> {1'b0, rd_addr_s1} < fill_q)
		else $error("pop cleared an entry above the fill point");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |-> !sts.full)
		else $error("push written into a full pool");

endmodule

// File: hdl/shared_pool_multi_stack_unit.sv
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_unit
// Many stacks sharing one pool; push at the fill point, pop by backward scan.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | in_data  : mode, stack_id, push_value
//  out     | out_valid/ out_ready | out_data : status, pop_value
//
//  Push, or pop of id zero or of an empty pool: decide state, then emit.
//  Pop: decide, then a scan of entries from the newest, one per cycle
//  through the id memory read port, then fetch on a hit, and emit.
//  Reset clears the fill point, scan pointer and control state; pool memories need no clearing.
//  A new item is taken while a result waits in the output register; a
//  stalled output holds the next result in the emit state.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spms_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output spms_pkg::out_t out_data
);
	import spms_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	spms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spms_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// File: sim/shared_pool_multi_stack_unit_tb.sv
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_unit_tb
// Self-checking bench for the shared-pool multi-stack unit. Each request
// transfer updates a behavioural copy of the pool, and every response is
// compared in order against it. Directed pushes and pops come first, then
// random traffic under several idle/stall mixes, each phase drained before
// the next.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spms_pkg::*;

	localparam int RANDOM_PER_PHASE = 20;
	localparam int WATCHDOG_LIMIT   = 4 * POOL_DEPTH + 10000;
	localparam int DRAIN_CYCLES     = 20;

	class pool_tracker;
		logic [ID_W-1:0]  id_mem  [POOL_DEPTH];
		logic [VAL_W-1:0] val_mem [POOL_DEPTH];
		int               fill_level = 0;
		out_t             pending_replies [$];
		int               mismatches = 0;

		function void apply_request(in_t req);
			out_t want;
			want = '0;
			if (req.mode == MODE_PUSH) begin
				if (fill_level >= POOL_DEPTH) begin
					want.status = ST_FULL;
				end else begin
					id_mem[fill_level]  = req.stack_id;
					val_mem[fill_level] = req.push_value;
					fill_level++;
					want.status = ST_PUSHED;
				end
			end else begin
				want.status = ST_EMPTY;
				if (req.stack_id != ID_CLEARED) begin
					for (int i = fill_level - 1; i >= 0; i--) begin
						if (id_mem[i] == req.stack_id) begin
							id_mem[i]      = ID_CLEARED;
							want.status    = ST_POPPED;
							want.pop_value = val_mem[i];
							break;
						end
					end
				end
			end
			pending_replies.push_back(want);
		endfunction

		function void check_reply(out_t got);
			out_t want;
			if (pending_replies.size() == 0) begin
				$error("unexpected response: status %0d pop_value 0x%08h",
					got.status, got.pop_value);
				mismatches++;
				return;
			end
			want = pending_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.pop_value !== want.pop_value) begin
				$error("pop_value: expected 0x%08h, actual 0x%08h",
					want.pop_value, got.pop_value);
				mismatches++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int          in_idle_pct   = 0;
	int          out_stall_pct = 0;
	int unsigned quiet_cycles  = 0;

	pool_tracker tracker = new;

	shared_pool_multi_stack_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// response side: check, stall, watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready)
			tracker.check_reply(out_data);
		out_ready <= !($urandom_range(99) < out_stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("** shared_pool_multi_stack_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_request(input in_t req);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		tracker.apply_request(req);
	endtask

	task automatic send_op(input logic mode, input logic [ID_W-1:0] sid,
		input logic [VAL_W-1:0] value);
		in_t req;
		req.mode       = mode;
		req.stack_id   = sid;
		req.push_value = value;
		send_request(req);
	endtask

	// hold off new requests until every response is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_replies.size() != 0);
	endtask

	function automatic in_t random_request();
		logic [ID_W-1:0] favourites [8] = '{10'd1, 10'd2, 10'd3, 10'd512, 10'd1023,
			10'h155, 10'h2AA, ID_CLEARED};
		in_t req;
		req.mode       = ($urandom_range(99) < 55) ? MODE_PUSH : MODE_POP;
		req.stack_id   = ($urandom_range(99) < 80) ? favourites[$urandom_range(7)]
			: ID_W'($urandom_range(1023));
		req.push_value = VAL_W'($urandom());
		return req;
	endfunction

	task automatic random_phase(input int idle_pct, input int stall_pct);
		in_idle_pct   = idle_pct;
		out_stall_pct = stall_pct;
		repeat (RANDOM_PER_PHASE) send_request(random_request());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_op(MODE_PUSH, 10'd1, 30'd0);
		send_op(MODE_PUSH, 10'd1023, 30'h3FFFFFFF);
		send_op(MODE_PUSH, ID_CLEARED, 30'h2AAAAAAA);
		send_op(MODE_PUSH, 10'd512, 30'h15555555);
		send_op(MODE_POP, ID_CLEARED, 30'd0);
		send_op(MODE_POP, 10'd1023, 30'd0);
		send_op(MODE_POP, 10'd1023, 30'd0);
		send_op(MODE_POP, 10'd1, 30'd0);
		send_op(MODE_PUSH, 10'd5, 30'd1);
		send_op(MODE_PUSH, 10'd5, 30'd2);
		send_op(MODE_PUSH, 10'd6, 30'd3);
		send_op(MODE_PUSH, 10'd5, 30'd4);
		send_op(MODE_POP, 10'd5, 30'h3FFFFFFF);
		send_op(MODE_POP, 10'd5, 30'd0);
		send_op(MODE_POP, 10'd6, 30'd0);
		send_op(MODE_POP, 10'd5, 30'd0);
		send_op(MODE_POP, 10'd5, 30'd0);
		send_op(MODE_POP, 10'd512, 30'd0);
		send_op(MODE_POP, 10'd700, 30'd0);
		send_op(MODE_POP, 10'h2AA, 30'h3FFFFFFF);
		send_op(MODE_PUSH, 10'h155, 30'h2AAAAAAA);
		send_op(MODE_POP, 10'h155, 30'd0);
		wait_drained();

		random_phase(0, 0);
		random_phase(51, 0);
		random_phase(0, 51);
		random_phase(31, 31);

		in_valid <= 1'b0;
		while (tracker.pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("** shared_pool_multi_stack_unit: PASSED **");
		end else begin
			$display("** shared_pool_multi_stack_unit: FAILED **");
		end
		$finish;
	end

endmodule
